// File: design/mf_pkg.sv
// shared constants, types and state codes for the median filter
package mf_pkg;

  localparam int MAX_WINDOW = 7;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W  = 8;
  localparam int CFG_W  = 11;
  localparam int WS_W   = 3;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 10;
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int NLANE  = MAX_WINDOW * MAX_WINDOW;
  localparam int CNT_W  = $clog2(NLANE + 1);
  localparam int DEPTH  = MAX_WINDOW * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BIT_W  = $clog2(PIX_W);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_START,
    ST_LOAD,
    ST_LWAIT,
    ST_SELECT,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic run;
  } sel_ctrl_t;

endpackage

// File: design/mf_ram.sv
// generic single-port ram with registered read
module mf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/mf_sel.sv
// bit-serial rank selector: picks the element of rank count/2, msb plane first
module mf_sel
  import mf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  sel_ctrl_t        ctrl,
  input  logic [PIX_W-1:0] din,
  output logic [PIX_W-1:0] median
);

  logic [PIX_W-1:0] lane_r [NLANE];
  logic [PIX_W-1:0] lane_nxt [NLANE];
  logic [NLANE-1:0] act_r, act_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [PIX_W-1:0] res_r, res_nxt;
  logic [NLANE-1:0] msb_v;
  logic [CNT_W-1:0] zeros;
  logic             take1;

  always_comb begin
    zeros = '0;
    for (int l = 0; l < NLANE; l++) begin
      msb_v[l] = lane_r[l][PIX_W-1];
      zeros    = zeros + CNT_W'(act_r[l] & ~lane_r[l][PIX_W-1]);
    end
    take1 = (k_r >= zeros);
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      lane_nxt[l] = lane_r[l];
    end
    act_nxt = act_r;
    cnt_nxt = cnt_r;
    k_nxt   = k_r;
    res_nxt = res_r;
    if (ctrl.clear) begin
      act_nxt = '0;
      cnt_nxt = '0;
      k_nxt   = '0;
    end else if (ctrl.load) begin
      lane_nxt[0] = din;
      for (int l = 1; l < NLANE; l++) begin
        lane_nxt[l] = lane_r[l-1];
      end
      act_nxt = {act_r[NLANE-2:0], 1'b1};
      cnt_nxt = cnt_r + 1'b1;
      k_nxt   = CNT_W'((cnt_r + 1'b1) >> 1);
    end else if (ctrl.run) begin
      // keep the half that holds the wanted rank, then move to the next plane
      if (take1) begin
        act_nxt = act_r & msb_v;
        k_nxt   = k_r - zeros;
      end else begin
        act_nxt = act_r & ~msb_v;
      end
      res_nxt = {res_r[PIX_W-2:0], take1};
      for (int l = 0; l < NLANE; l++) begin
        lane_nxt[l] = {lane_r[l][PIX_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      cnt_r <= '0;
      k_r   <= '0;
    end else begin
      act_r <= act_nxt;
      cnt_r <= cnt_nxt;
      k_r   <= k_nxt;
    end
    res_r <= res_nxt;
    for (int l = 0; l < NLANE; l++) begin
      lane_r[l] <= lane_nxt[l];
    end
  end

  assign median = res_r;

endmodule

// File: design/sliding_window_median_filter.sv
// top level: line store, window sequencer and bit-serial median selection
// Each accepted pixel is written to a line store of MAX_WINDOW rows; then,
// for each output whose clipped window ends at that pixel, the window is
// read from the store one byte a cycle (an n-entry window holds up to 49
// entries), with a set-up state (ST_START) before and a drain state
// (ST_LWAIT) after, and the median is found one bit plane at a time, msb
// plane first, before the result is offered. A pixel that ends no window
// goes back to idle once written. No new pixel is taken until every window
// that a pixel ends has been offered and taken; output stalls hold it.
// The line store's single port sets the load time; it needs no clearing.
module sliding_window_median_filter
  import mf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pixel,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_median,
  output logic [ROW_W-1:0] out_row,
  output logic [COL_W-1:0] out_col,
  output logic             out_last,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  st_t state_r, state_nxt;

  logic [CFG_W-1:0]  wid_cfg_r, hgt_cfg_r;
  logic [WS_W-1:0]   win_cfg_r;
  logic [ROW_W-1:0]  rpos_r, i_r, ihi_r, y_r;
  logic [COL_W-1:0]  cpos_r, j_r, jlo_r, jhi_r, x_r;
  logic [SLOT_W-1:0] slot_r, yslot_r;
  logic [PIX_W-1:0]  pix_r;
  logic              rd_pend_r;
  logic [BIT_W-1:0]  bit_r;

  logic [CFG_W-1:0]  w_eff, h_eff;
  logic [WIN_W-1:0]  m_eff;

  // effective sizes
  always_comb begin
    if (wid_cfg_r == '0) w_eff = CFG_W'(1);
    else if (wid_cfg_r > CFG_W'(MAX_WIDTH)) w_eff = CFG_W'(MAX_WIDTH);
    else w_eff = wid_cfg_r;
    if (hgt_cfg_r == '0) h_eff = CFG_W'(1);
    else if (hgt_cfg_r > CFG_W'(MAX_HEIGHT)) h_eff = CFG_W'(MAX_HEIGHT);
    else h_eff = hgt_cfg_r;
    if (win_cfg_r == '0) m_eff = WIN_W'(1);
    else if (WS_W'(win_cfg_r) > WS_W'(MAX_WINDOW)) m_eff = WIN_W'(MAX_WINDOW);
    else m_eff = WIN_W'(win_cfg_r);
  end

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(MAX_WINDOW - 1)) ? '0 : s + 1'b1;
  endfunction

  // position normalised at accept (sizes may have changed)
  logic              c_wrap, r_wrap;
  logic [CFG_W-1:0]  r_a;
  logic [SLOT_W-1:0] slot_a;
  always_comb begin
    c_wrap = ({1'b0, cpos_r} >= w_eff);
    r_a    = c_wrap ? {1'b0, rpos_r} + 1'b1 : {1'b0, rpos_r};
    slot_a = c_wrap ? slot_inc(slot_r) : slot_r;
    r_wrap = (r_a >= h_eff);
  end

  // position after the item
  logic              adv_cw, adv_rw;
  logic [CFG_W-1:0]  c1, r1;
  always_comb begin
    c1     = {1'b0, cpos_r} + 1'b1;
    r1     = {1'b0, rpos_r} + 1'b1;
    adv_cw = (c1 >= w_eff);
    adv_rw = (r1 >= h_eff);
  end

  // range of outputs that end at this pixel
  logic             rows_ok, cols_ok;
  logic [ROW_W-1:0] ilo_c, ihi_c;
  logic [COL_W-1:0] jlo_c, jhi_c;
  always_comb begin
    ilo_c   = (r1 >= CFG_W'(m_eff)) ? ROW_W'(r1 - CFG_W'(m_eff)) : '0;
    rows_ok = (r1 == h_eff) || (r1 >= CFG_W'(m_eff));
    ihi_c   = (r1 == h_eff) ? rpos_r : ilo_c;
    jlo_c   = (c1 >= CFG_W'(m_eff)) ? COL_W'(c1 - CFG_W'(m_eff)) : '0;
    cols_ok = (c1 == w_eff) || (c1 >= CFG_W'(m_eff));
    jhi_c   = (c1 == w_eff) ? cpos_r : jlo_c;
  end

  // store slot of the window's top row
  logic [SLOT_W-1:0] di, top_slot;
  always_comb begin
    di       = SLOT_W'(rpos_r - i_r);
    top_slot = (slot_r >= di) ? slot_r - di
             : SLOT_W'(SLOT_W'(MAX_WINDOW) + slot_r - di);
  end

  logic last_c, x_end, y_end;
  assign last_c = (i_r == ihi_r) && (j_r == jhi_r);
  assign x_end  = (x_r == cpos_r);
  assign y_end  = (y_r == rpos_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_WRITE;
      ST_WRITE:  state_nxt = (rows_ok && cols_ok) ? ST_START : ST_IDLE;
      ST_START:  state_nxt = ST_LOAD;
      ST_LOAD:   if (x_end && y_end) state_nxt = ST_LWAIT;
      ST_LWAIT:  state_nxt = ST_SELECT;
      ST_SELECT: if (bit_r == BIT_W'(PIX_W - 1)) state_nxt = ST_OUT;
      ST_OUT:    if (out_ready) state_nxt = last_c ? ST_IDLE : ST_START;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  sel_ctrl_t          sel_ctrl;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [PIX_W-1:0]   ram_rdata;
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = ADDR_W'(yslot_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_r);
    sel_ctrl      = '0;
    sel_ctrl.load = rd_pend_r;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_WRITE: begin
        ram_we   = 1'b1;
        ram_addr = ADDR_W'(slot_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cpos_r);
      end
      ST_START:  sel_ctrl.clear = 1'b1;
      ST_SELECT: sel_ctrl.run = 1'b1;
      ST_OUT:    out_valid = 1'b1;
      default: ;
    endcase
  end

  mf_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (pix_r),
    .rdata (ram_rdata)
  );

  mf_sel u_sel (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (sel_ctrl),
    .din    (ram_rdata),
    .median (out_median)
  );

  logic adv;
  assign adv = ((state_r == ST_WRITE) && !(rows_ok && cols_ok))
            || ((state_r == ST_OUT) && out_ready && last_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wid_cfg_r <= CFG_W'(640);
      hgt_cfg_r <= CFG_W'(480);
      win_cfg_r <= WS_W'(3);
      rpos_r    <= '0;
      cpos_r    <= '0;
      slot_r    <= '0;
      rd_pend_r <= 1'b0;
      bit_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == ST_LOAD);
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  wid_cfg_r <= cfg_data;
          REG_HEIGHT: hgt_cfg_r <= cfg_data;
          REG_WINDOW: win_cfg_r <= cfg_data[WS_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_IDLE && in_valid) begin
        cpos_r <= c_wrap ? '0 : cpos_r;
        rpos_r <= r_wrap ? '0 : ROW_W'(r_a);
        slot_r <= r_wrap ? '0 : slot_a;
      end else if (adv) begin
        if (adv_cw) begin
          cpos_r <= '0;
          rpos_r <= adv_rw ? '0 : ROW_W'(r1);
          slot_r <= adv_rw ? '0 : slot_inc(slot_r);
        end else begin
          cpos_r <= COL_W'(c1);
        end
      end
      if (state_r == ST_LWAIT) bit_r <= '0;
      else if (state_r == ST_SELECT) bit_r <= bit_r + 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) pix_r <= in_pixel;
    if (state_r == ST_WRITE) begin
      ihi_r <= ihi_c;
      jlo_r <= jlo_c;
      jhi_r <= jhi_c;
      i_r   <= ilo_c;
      j_r   <= jlo_c;
    end
    if (state_r == ST_START) begin
      y_r     <= i_r;
      x_r     <= j_r;
      yslot_r <= top_slot;
    end
    if (state_r == ST_LOAD) begin
      if (x_end) begin
        x_r     <= j_r;
        y_r     <= y_r + 1'b1;
        yslot_r <= slot_inc(yslot_r);
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
    if (state_r == ST_OUT && out_ready && !last_c) begin
      if (j_r == jhi_r) begin
        j_r <= jlo_r;
        i_r <= i_r + 1'b1;
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
  end

  assign out_row  = i_r;
  assign out_col  = j_r;
  assign out_last = last_c;

endmodule

// File: bench/sliding_window_median_filter_tb.sv
// self-checking testbench for the sliding window median filter
module sliding_window_median_filter_tb;
  import mf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [PIX_W-1:0] median;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } pix_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [PIX_W-1:0] in_pixel;
  logic             out_valid;
  logic             out_ready;
  logic [PIX_W-1:0] out_median;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             out_last;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  sliding_window_median_filter DUT (.*);

  // predictor state
  int unsigned cur_width, cur_height, cur_win;
  logic [PIX_W-1:0] frame_store [MAX_WINDOW*MAX_WIDTH];
  int unsigned pos_row, pos_col;
  pix_result_t expected_medians [$];

  int  err_count;
  int  idle_cycles;
  bit  hold_off;
  int  burst_left;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] window_median(int unsigned i, int unsigned j,
                                                     int unsigned r, int unsigned c);
    logic [PIX_W-1:0] vals [$];
    for (int unsigned y = i; y <= r; y++)
      for (int unsigned x = j; x <= c; x++)
        vals.push_back(frame_store[(y % MAX_WINDOW)*MAX_WIDTH + x]);
    vals.sort();
    return vals[vals.size()/2];
  endfunction

  task automatic predict_medians(logic [PIX_W-1:0] pix);
    int unsigned w, h, m, r, c, ilo, ihi, jlo, jhi;
    bit rows_ok, cols_ok;
    pix_result_t res;
    w = clamp_dim(cur_width, MAX_WIDTH);
    h = clamp_dim(cur_height, MAX_HEIGHT);
    m = clamp_dim(cur_win, MAX_WINDOW);
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    r = pos_row;
    c = pos_col;
    frame_store[(r % MAX_WINDOW)*MAX_WIDTH + c] = pix;
    rows_ok = 1;
    ihi = r;
    if (r == h-1) ilo = (r+1 >= m) ? r+1-m : 0;
    else if (r+1 >= m) begin
      ilo = r+1-m;
      ihi = ilo;
    end else begin
      rows_ok = 0;
      ilo = 0;
    end
    cols_ok = 1;
    jhi = c;
    if (c == w-1) jlo = (c+1 >= m) ? c+1-m : 0;
    else if (c+1 >= m) begin
      jlo = c+1-m;
      jhi = jlo;
    end else begin
      cols_ok = 0;
      jlo = 0;
    end
    if (rows_ok && cols_ok)
      for (int unsigned i = ilo; i <= ihi; i++)
        for (int unsigned j = jlo; j <= jhi; j++) begin
          res.median = window_median(i, j, r, c);
          res.row = i[ROW_W-1:0];
          res.col = j[COL_W-1:0];
          res.last = (i == ihi && j == jhi);
          expected_medians.push_back(res);
        end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    err_count++;
  endtask

  // sender: bursts with random gaps
  task automatic send_pixel(logic [PIX_W-1:0] pix);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    in_pixel <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_medians(pix);
    @(negedge clk);
  endtask

  // drop valid once a run of items is over
  task automatic end_burst();
    in_valid <= 0;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    while (expected_medians.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_WIDTH:  cur_width = val & 11'h7ff;
      REG_HEIGHT: cur_height = val & 11'h7ff;
      REG_WINDOW: cur_win = val & 3'h7;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // sizes change only once every expected result has drained; the position is not reset
  task automatic set_frame(int unsigned w, int unsigned h, int unsigned m);
    wait_drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_WINDOW, m);
  endtask

  function automatic int unsigned frame_pixels();
    return clamp_dim(cur_width, MAX_WIDTH) * clamp_dim(cur_height, MAX_HEIGHT);
  endfunction

  // frames must be sent whole, from position 0
  task automatic send_frame(int mode);
    int unsigned n;
    n = frame_pixels();
    for (int unsigned k = 0; k < n; k++)
      case (mode)
        0: send_pixel($urandom_range(0, 255));
        1: send_pixel((k & 1) ? 8'hff : 8'h00);
        default: send_pixel($urandom_range(0, 1) ? 8'hff : 8'h00);
      endcase
    end_burst();
  endtask

  task automatic test_extremes();
    set_frame(3, 3, 3);
    send_frame(1);
    set_frame(1, 1, 1);
    send_pixel(8'h00);
    send_pixel(8'hff);
    end_burst();
    set_frame(2, 2, 7);
    send_frame(2);
  endtask

  task automatic test_special_sizes();
    set_frame(0, 2, 0);
    send_frame(0);
    set_frame(2, 0, 2);
    send_frame(0);
    set_frame(2047, 1, 7);
    repeat (40) send_pixel($urandom_range(0, 255));
    end_burst();
    // a narrower row leaves the position past the row end, so it wraps to the start
    set_frame(4, 1, 2);
    send_frame(0);
    set_frame(4, 2, 2);
    write_reg(2'd3, 5);
    send_frame(0);
  endtask

  task automatic test_backpressure();
    set_frame(5, 5, 3);
    hold_off = 1;
    send_frame(0);
    wait (hold_off == 0);
  endtask

  task automatic test_random_frames();
    int sent;
    sent = 0;
    while (sent < 220) begin
      set_frame($urandom_range(1, 9), $urandom_range(1, 7), $urandom_range(1, 7));
      sent += frame_pixels();
      send_frame($urandom_range(0, 3) == 0 ? 2 : 0);
    end
    set_frame(7, 7, 7);
    send_frame(0);
  endtask

  // receiver stall pattern and long hold-off
  initial begin
    int stall_phase;
    out_ready = 0;
    stall_phase = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      stall_phase = (stall_phase + 1) % 64;
      if (stall_phase < 20) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // result checker
  initial begin
    pix_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_medians.size() == 0) begin
          $display("unexpected result at row %0d col %0d", out_row, out_col);
          err_count++;
        end else begin
          want = expected_medians.pop_front();
          if (out_median !== want.median) report_mismatch("median", out_median, want.median);
          if (out_row !== want.row) report_mismatch("row", out_row, want.row);
          if (out_col !== want.col) report_mismatch("col", out_col, want.col);
          if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        end
      end
    end
  end

  // watchdog on handshake inactivity
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_pixel = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    err_count = 0;
    hold_off = 0;
    burst_left = 0;
    cur_width = 640;
    cur_height = 480;
    cur_win = 3;
    pos_row = 0;
    pos_col = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    test_extremes();
    test_special_sizes();
    test_backpressure();
    test_random_frames();
    wait_drain();
    if (err_count == 0 && expected_medians.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
